FILE: src/hs5_pkg.sv
// Shared constants and types of the five-point heat stencil block
package hs5_pkg;

    // Default sizing
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int TEMP_BITS  = 24;

    // Result index fields
    localparam int ROW_OUT_W = 10;
    localparam int COL_OUT_W = 8;

    typedef logic [ROW_OUT_W-1:0] t_row_out;
    typedef logic [COL_OUT_W-1:0] t_col_out;

    // Configuration registers
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int GRID_W_W  = 9;
    localparam int GRID_H_W  = 11;
    localparam int SRC_COL_W = 8;
    localparam int SRC_ROW_W = 10;

    localparam logic [GRID_W_W-1:0]  GRID_WIDTH_RST  = 9'd200;
    localparam logic [GRID_H_W-1:0]  GRID_HEIGHT_RST = 11'd200;
    localparam logic [SRC_COL_W-1:0] SOURCE_COL_RST  = 8'd50;
    localparam logic [SRC_ROW_W-1:0] SOURCE_ROW_RST  = 10'd25;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_SOURCE_COL  = 2'd2,
        REG_SOURCE_ROW  = 2'd3
    } t_reg_idx;

    // Line buffers: one per row slot (row mod 3)
    localparam int LINE_BUFS = 3;

    // Diffusion coefficient 0.2 in Q0.16
    localparam int               FRAC_BITS  = 16;
    localparam logic [15:0]      COEF_Q16   = 16'd13107;
    localparam logic [15:0]      ROUND_HALF = 16'd32768;

    // Bit positions of the pending-result mask, in emission order
    localparam int RES_UP     = 0;  // cell one row above the request
    localparam int RES_LEFT   = 1;  // last row, cell left of the request
    localparam int RES_CORNER = 2;  // last row, final column
    localparam int RES_KINDS  = 3;

    // Bookkeeping that travels with each result through the pipeline
    typedef struct packed {
        t_row_out row;
        t_col_out col;
        logic     last;
        logic     done;
        logic     src;
    } t_meta;

endpackage

FILE: src/hs5_if.sv
// Request and result stream interfaces of the heat stencil block
interface hs5_in_if #(
    parameter int TEMP_BITS = hs5_pkg::TEMP_BITS
);
    logic                 valid;
    logic                 ready;
    logic [TEMP_BITS-1:0] cell_temp;

    modport source (output valid, output cell_temp, input ready);
    modport sink   (input valid, input cell_temp, output ready);
endinterface

interface hs5_out_if #(
    parameter int TEMP_BITS = hs5_pkg::TEMP_BITS
);
    logic                   valid;
    logic                   ready;
    logic [TEMP_BITS-1:0]   new_temp;
    hs5_pkg::t_row_out      out_row;
    hs5_pkg::t_col_out      out_col;
    logic                   run_last;
    logic                   frame_done;

    modport source (output valid, output new_temp, output out_row, output out_col,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input new_temp, input out_row, input out_col,
                    input run_last, input frame_done, output ready);
endinterface

FILE: src/hs5_ram.sv
// Generic RAM: one write port, two read ports with registered read data
module hs5_ram #(
    parameter int WIDTH = hs5_pkg::TEMP_BITS,
    parameter int DEPTH = hs5_pkg::MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

FILE: src/heat_stencil_5pt_step_top.sv
// Five-point heat stencil, one time step over a grid streamed in raster order.
// i_in takes one cell temperature per request (unsigned Q10.14), row by row.
// o_out gives updated cells with their row and column; run_last marks the
// last result caused by a request and frame_done the final cell of the grid.
// The first row gives no result, rows 1..H-1 give the cell one row above,
// the last row also gives the cell to its left, and its final request also
// gives the corner cell. The APB port holds grid size and source position;
// write it only while the block is idle.
// Each result passes the request stage, p1, p2, p3 and the output register.
// Throughput: one request per cycle while o_out is ready; in the last row the
// single output port holds each request until all of its results have issued.
// Three line buffers of MAX_WIDTH entries each hold the previous rows; they
// need no clearing, so the block takes requests right after reset.
// Reset returns the grid position to row 0, column 0 and the registers to
// their defaults. When o_out stalls, the whole pipeline holds and i_in.ready
// drops while the request stage holds a request with results still to issue.
module heat_stencil_5pt_step_top #(
    parameter int MAX_WIDTH  = hs5_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = hs5_pkg::MAX_HEIGHT,
    parameter int TEMP_BITS  = hs5_pkg::TEMP_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hs5_in_if.sink                        i_in,
    hs5_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hs5_pkg::PADDR_W-1:0]   paddr,
    input  logic [hs5_pkg::DATA_W-1:0]    pwdata,
    output logic [hs5_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MAG_W  = TEMP_BITS + 2;
    localparam int PROD_W = MAG_W + hs5_pkg::FRAC_BITS;

    typedef logic [COL_W-1:0]     t_col;
    typedef logic [COL_W:0]       t_colc;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [ROW_W:0]       t_rowc;
    typedef logic [TEMP_BITS-1:0] t_temp;
    typedef logic [MAG_W-1:0]     t_mag;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [hs5_pkg::RES_KINDS-1:0] t_pend;

    localparam t_temp TEMP_MAX = '1;

    // ---------------- configuration registers ----------------
    logic [hs5_pkg::GRID_W_W-1:0]  r_grid_width;
    logic [hs5_pkg::GRID_H_W-1:0]  r_grid_height;
    logic [hs5_pkg::SRC_COL_W-1:0] r_source_col;
    logic [hs5_pkg::SRC_ROW_W-1:0] r_source_row;
    logic                          cfg_wr;
    hs5_pkg::t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = hs5_pkg::t_reg_idx'(paddr[hs5_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= hs5_pkg::GRID_WIDTH_RST;
            r_grid_height <= hs5_pkg::GRID_HEIGHT_RST;
            r_source_col  <= hs5_pkg::SOURCE_COL_RST;
            r_source_row  <= hs5_pkg::SOURCE_ROW_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                hs5_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[hs5_pkg::GRID_W_W-1:0];
                hs5_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[hs5_pkg::GRID_H_W-1:0];
                hs5_pkg::REG_SOURCE_COL:  r_source_col  <= pwdata[hs5_pkg::SRC_COL_W-1:0];
                hs5_pkg::REG_SOURCE_ROW:  r_source_row  <= pwdata[hs5_pkg::SRC_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            hs5_pkg::REG_GRID_WIDTH:  prdata = hs5_pkg::DATA_W'(r_grid_width);
            hs5_pkg::REG_GRID_HEIGHT: prdata = hs5_pkg::DATA_W'(r_grid_height);
            hs5_pkg::REG_SOURCE_COL:  prdata = hs5_pkg::DATA_W'(r_source_col);
            hs5_pkg::REG_SOURCE_ROW:  prdata = hs5_pkg::DATA_W'(r_source_row);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- grid position ----------------
    t_colc w_eff;
    t_rowc h_eff;
    t_col  r_col;
    t_row  r_row;
    logic [1:0] r_slot;        // r_row mod 3
    t_col  pos_col;
    t_rowc pos_row;
    logic [1:0] pos_slot;
    t_colc col_inc;
    t_rowc row_inc;
    t_col  n_col;
    t_row  n_row;
    logic [1:0] n_slot;
    logic [1:0] slot_m;        // slot of the row above
    logic [1:0] slot_u;        // slot of the row two above

    always_comb begin
        if (r_grid_width < hs5_pkg::GRID_W_W'(2)) begin
            w_eff = t_colc'(2);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_eff = t_colc'(MAX_WIDTH);
        end else begin
            w_eff = t_colc'(r_grid_width);
        end
        if (r_grid_height < hs5_pkg::GRID_H_W'(2)) begin
            h_eff = t_rowc'(2);
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            h_eff = t_rowc'(MAX_HEIGHT);
        end else begin
            h_eff = t_rowc'(r_grid_height);
        end

        // a position left outside a shrunk grid wraps first
        pos_col  = r_col;
        pos_row  = t_rowc'(r_row);
        pos_slot = r_slot;
        if (t_colc'(r_col) >= w_eff) begin
            pos_col  = '0;
            pos_row  = t_rowc'(r_row) + t_rowc'(1);
            pos_slot = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
        end
        if (pos_row >= h_eff) begin
            pos_row  = '0;
            pos_slot = 2'd0;
        end

        col_inc = t_colc'(pos_col) + t_colc'(1);
        row_inc = pos_row + t_rowc'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row  = '0;
                n_slot = 2'd0;
            end else begin
                n_row  = t_row'(row_inc);
                n_slot = (pos_slot == 2'd2) ? 2'd0 : pos_slot + 2'd1;
            end
        end else begin
            n_col  = t_col'(col_inc);
            n_row  = t_row'(pos_row);
            n_slot = pos_slot;
        end

        slot_m = (pos_slot == 2'd0) ? 2'd2 : pos_slot - 2'd1;
        case (pos_slot)
            2'd0:    slot_u = 2'd1;
            2'd1:    slot_u = 2'd2;
            default: slot_u = 2'd0;
        endcase
    end

    // ---------------- request handshake and line buffers ----------------
    logic  in_acc;
    logic  adv;
    logic  issue;
    logic  retire;
    logic  r_s1_valid;
    t_pend r_s1_pend;
    t_pend pend_rest;
    t_pend pick;
    logic [TEMP_BITS-1:0] rd0 [hs5_pkg::LINE_BUFS];
    logic [TEMP_BITS-1:0] rd1 [hs5_pkg::LINE_BUFS];

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_valid || retire;

    for (genvar b = 0; b < hs5_pkg::LINE_BUFS; b++) begin : g_bank
        hs5_ram #(
            .WIDTH (TEMP_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk    (i_clk),
            .i_we     (in_acc && (pos_slot == 2'(b))),
            .i_waddr  (pos_col),
            .i_wdata  (i_in.cell_temp),
            .i_re     (in_acc),
            .i_raddr0 (pos_col),
            .i_raddr1 (pos_col + t_col'(1)),
            .o_rdata0 (rd0[b]),
            .o_rdata1 (rd1[b])
        );
    end

    // ---------------- request stage ----------------
    t_temp r_s1_cell;
    t_row  r_s1_row;
    t_col  r_s1_col;
    logic [1:0] r_s1_slot_m;
    logic [1:0] r_s1_slot_u;
    logic  r_s1_c0;
    logic  r_s1_c1;
    logic  r_s1_cl;
    logic  r_s1_r1;
    t_pend r_s1_src;
    t_pend n_pend;
    t_pend n_src;
    logic  last_row;

    always_comb begin
        last_row             = (pos_row == h_eff - t_rowc'(1));
        n_pend[hs5_pkg::RES_UP]     = (pos_row != '0);
        n_pend[hs5_pkg::RES_LEFT]   = last_row && (pos_col != '0);
        n_pend[hs5_pkg::RES_CORNER] = last_row && (t_colc'(pos_col) == w_eff - t_colc'(1));
        n_src[hs5_pkg::RES_UP]      = (32'(pos_row) == 32'(r_source_row) + 32'd1)
                                   && (32'(pos_col) == 32'(r_source_col));
        n_src[hs5_pkg::RES_LEFT]    = (32'(pos_row) == 32'(r_source_row))
                                   && (32'(pos_col) == 32'(r_source_col) + 32'd1);
        n_src[hs5_pkg::RES_CORNER]  = (32'(pos_row) == 32'(r_source_row))
                                   && (32'(pos_col) == 32'(r_source_col));
    end

    assign pend_rest = r_s1_pend & (r_s1_pend - t_pend'(1));
    assign pick      = r_s1_pend & ~pend_rest;
    assign issue     = r_s1_valid && (r_s1_pend != '0) && adv;
    assign retire    = r_s1_valid && ((r_s1_pend == '0) || (adv && (pend_rest == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pend  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_slot     <= 2'd0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_s1_pend  <= n_pend;
                r_col      <= n_col;
                r_row      <= n_row;
                r_slot     <= n_slot;
            end else if (retire) begin
                r_s1_valid <= 1'b0;
                r_s1_pend  <= '0;
            end else if (issue) begin
                r_s1_pend  <= pend_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cell   <= i_in.cell_temp;
            r_s1_row    <= t_row'(pos_row);
            r_s1_col    <= pos_col;
            r_s1_slot_m <= slot_m;
            r_s1_slot_u <= slot_u;
            r_s1_c0     <= (pos_col == '0);
            r_s1_c1     <= (pos_col == t_col'(1));
            r_s1_cl     <= (t_colc'(pos_col) == w_eff - t_colc'(1));
            r_s1_r1     <= (pos_row == t_rowc'(1));
            r_s1_src    <= n_src;
        end
    end

    // ---------------- neighbour window ----------------
    // r_m_prev: row above, one column left; r_d1/r_d2: this row, one and two left
    t_temp r_m_prev;
    t_temp r_d1;
    t_temp r_d2;
    t_temp m0;
    t_temp m1;
    t_temp u0;

    assign m0 = rd0[r_s1_slot_m];
    assign m1 = rd1[r_s1_slot_m];
    assign u0 = rd0[r_s1_slot_u];

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_m_prev <= m0;
            r_d1     <= r_s1_cell;
            r_d2     <= r_d1;
        end
    end

    t_temp iss_tc;
    t_temp iss_tl;
    t_temp iss_tr;
    t_temp iss_tu;
    t_temp iss_td;
    hs5_pkg::t_meta iss_meta;

    always_comb begin
        iss_meta.last = (pend_rest == '0);
        if (pick[hs5_pkg::RES_LEFT]) begin
            // last row, cell to the left; below the grid the centre stands in
            iss_tc        = r_d1;
            iss_tl        = r_s1_c1 ? r_d1 : r_d2;
            iss_tr        = r_s1_cell;
            iss_tu        = r_m_prev;
            iss_td        = r_d1;
            iss_meta.row  = hs5_pkg::t_row_out'(r_s1_row);
            iss_meta.col  = hs5_pkg::t_col_out'(r_s1_col - t_col'(1));
            iss_meta.done = 1'b0;
            iss_meta.src  = r_s1_src[hs5_pkg::RES_LEFT];
        end else if (pick[hs5_pkg::RES_CORNER]) begin
            iss_tc        = r_s1_cell;
            iss_tl        = r_d1;
            iss_tr        = r_s1_cell;
            iss_tu        = m0;
            iss_td        = r_s1_cell;
            iss_meta.row  = hs5_pkg::t_row_out'(r_s1_row);
            iss_meta.col  = hs5_pkg::t_col_out'(r_s1_col);
            iss_meta.done = 1'b1;
            iss_meta.src  = r_s1_src[hs5_pkg::RES_CORNER];
        end else begin
            iss_tc        = m0;
            iss_tl        = r_s1_c0 ? m0 : r_m_prev;
            iss_tr        = r_s1_cl ? m0 : m1;
            iss_tu        = r_s1_r1 ? m0 : u0;
            iss_td        = r_s1_cell;
            iss_meta.row  = hs5_pkg::t_row_out'(r_s1_row - t_row'(1));
            iss_meta.col  = hs5_pkg::t_col_out'(r_s1_col);
            iss_meta.done = 1'b0;
            iss_meta.src  = r_s1_src[hs5_pkg::RES_UP];
        end
    end

    // ---------------- arithmetic pipeline ----------------
    logic  r_p1_valid;
    t_temp r_p1_tc;
    t_temp r_p1_tl;
    t_temp r_p1_tr;
    t_temp r_p1_tu;
    t_temp r_p1_td;
    hs5_pkg::t_meta r_p1_meta;

    logic  r_p2_valid;
    t_mag  r_p2_mag;
    logic  r_p2_neg;
    t_temp r_p2_tc;
    hs5_pkg::t_meta r_p2_meta;

    logic  r_p3_valid;
    t_prod r_p3_prod;
    logic  r_p3_neg;
    t_temp r_p3_tc;
    hs5_pkg::t_meta r_p3_meta;

    logic  r_out_valid;
    t_temp r_out_temp;
    hs5_pkg::t_meta r_out_meta;

    t_mag  p_sum;
    t_mag  p_four;
    t_mag  n_mag;
    logic  n_neg;
    t_prod rnd;
    t_mag  delta;
    t_mag  up_sum;
    t_temp n_temp;

    assign adv = !r_out_valid || o_out.ready;

    always_comb begin
        p_sum  = t_mag'(r_p1_tl) + t_mag'(r_p1_tr) + t_mag'(r_p1_tu) + t_mag'(r_p1_td);
        p_four = t_mag'(r_p1_tc) << 2;
        n_neg  = (p_sum < p_four);
        n_mag  = n_neg ? (p_four - p_sum) : (p_sum - p_four);
    end

    always_comb begin
        rnd    = r_p3_prod + t_prod'(hs5_pkg::ROUND_HALF);
        delta  = rnd[PROD_W-1:hs5_pkg::FRAC_BITS];
        up_sum = t_mag'(r_p3_tc) + delta;
        if (r_p3_meta.src) begin
            n_temp = r_p3_tc;
        end else if (r_p3_neg) begin
            n_temp = (delta > t_mag'(r_p3_tc)) ? '0 : t_temp'(t_mag'(r_p3_tc) - delta);
        end else begin
            n_temp = (up_sum > t_mag'(TEMP_MAX)) ? TEMP_MAX : t_temp'(up_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid  <= issue;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_tc    <= iss_tc;
            r_p1_tl    <= iss_tl;
            r_p1_tr    <= iss_tr;
            r_p1_tu    <= iss_tu;
            r_p1_td    <= iss_td;
            r_p1_meta  <= iss_meta;

            r_p2_mag   <= n_mag;
            r_p2_neg   <= n_neg;
            r_p2_tc    <= r_p1_tc;
            r_p2_meta  <= r_p1_meta;

            r_p3_prod  <= t_prod'(r_p2_mag) * t_prod'(hs5_pkg::COEF_Q16);
            r_p3_neg   <= r_p2_neg;
            r_p3_tc    <= r_p2_tc;
            r_p3_meta  <= r_p2_meta;

            r_out_temp <= n_temp;
            r_out_meta <= r_p3_meta;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.new_temp   = r_out_temp;
    assign o_out.out_row    = r_out_meta.row;
    assign o_out.out_col    = r_out_meta.col;
    assign o_out.run_last   = r_out_meta.last;
    assign o_out.frame_done = r_out_meta.done;

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("row slot counter out of range");

    a_multi_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && ($countones(r_s1_pend) >= 2)) |-> !i_in.ready)
        else $error("new request taken while results of the current one remain");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_meta.done) |-> r_out_meta.last)
        else $error("frame end not marked as last result of its request");

    a_corner_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pend[hs5_pkg::RES_CORNER]) |-> r_s1_cl)
        else $error("corner result pending away from the final column");
`endif

endmodule
